@@ rtl/core/bsg_pkg.sv @@
package bsg_pkg;

	localparam int ADC_BITS       = 12;
	localparam int AVG_LENGTH_DEF = 20;
	localparam int TABLE_ENTRIES  = 101;
	localparam int ROM_STORED     = 101;
	localparam int ROM_IDX_W      = $clog2(ROM_STORED);
	localparam int IDX_W          = 8;
	localparam int LVL_W          = ADC_BITS + 4;
	localparam int AVG_W          = 16;
	localparam int PCT_W          = 7;
	localparam int VOLT_W         = 17;
	localparam int QUEUE_DEPTH    = 2;

	localparam longint unsigned FS16     = ((64'd1 << ADC_BITS) - 64'd1) * 64'd16;
	localparam longint unsigned ROM_DEN  = 64'd82500;
	localparam longint unsigned ROM_HALF = 64'd41250;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	localparam logic [1:0] BAND_NONE     = 2'd0;
	localparam logic [1:0] BAND_SHUTDOWN = 2'd1;
	localparam logic [1:0] BAND_LOW      = 2'd2;
	localparam logic [1:0] BAND_NORMAL   = 2'd3;

	localparam logic REG_SHUTDOWN = 1'b0;
	localparam logic REG_LOW_WARN = 1'b1;

	localparam logic [PCT_W-1:0] SHUTDOWN_RST = 7'd5;
	localparam logic [PCT_W-1:0] LOW_WARN_RST = 7'd20;

	typedef struct packed {
		logic                operation;
		logic [ADC_BITS-1:0] adc_code;
	} soc_req_t;

	typedef struct packed {
		logic             soc_valid;
		logic [PCT_W-1:0] soc_percent;
		logic [1:0]       charge_band;
		logic             low_warning;
		logic             turn_on_ok;
		logic [AVG_W-1:0] average_level;
	} soc_res_t;

	typedef struct packed {
		logic                kind;
		logic [ADC_BITS-1:0] code;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	typedef struct packed {
		logic [PCT_W-1:0] shutdown_max;
		logic [PCT_W-1:0] low_warn_max;
	} soc_cfg_t;

	typedef logic [0:ROM_STORED-1][VOLT_W-1:0] volt_rom_t;
	typedef logic [0:ROM_STORED-1][LVL_W-1:0]  level_rom_t;

	// battery volts in units of 1e-4 V, one entry per percent
	localparam volt_rom_t VOLT_ROM = '{
		17'd63900, 17'd64203, 17'd64484, 17'd64746, 17'd64990,
		17'd65221, 17'd65440, 17'd65649, 17'd65853, 17'd66050,
		17'd66240, 17'd66424, 17'd66599, 17'd66767, 17'd66925,
		17'd67074, 17'd67215, 17'd67350, 17'd67484, 17'd67620,
		17'd67758, 17'd67897, 17'd68036, 17'd68174, 17'd68312,
		17'd68450, 17'd68588, 17'd68726, 17'd68865, 17'd69002,
		17'd69139, 17'd69275, 17'd69413, 17'd69553, 17'd69696,
		17'd69842, 17'd69991, 17'd70142, 17'd70296, 17'd70451,
		17'd70608, 17'd70767, 17'd70926, 17'd71086, 17'd71248,
		17'd71410, 17'd71575, 17'd71740, 17'd71907, 17'd72076,
		17'd72246, 17'd72416, 17'd72585, 17'd72752, 17'd72916,
		17'd73076, 17'd73231, 17'd73380, 17'd73524, 17'd73664,
		17'd73800, 17'd73933, 17'd74065, 17'd74194, 17'd74324,
		17'd74453, 17'd74585, 17'd74720, 17'd74859, 17'd75003,
		17'd75155, 17'd75314, 17'd75481, 17'd75655, 17'd75834,
		17'd76018, 17'd76206, 17'd76397, 17'd76589, 17'd76782,
		17'd76974, 17'd77161, 17'd77343, 17'd77516, 17'd77680,
		17'd77832, 17'd77971, 17'd78100, 17'd78222, 17'd78339,
		17'd78456, 17'd78574, 17'd78696, 17'd78827, 17'd78968,
		17'd79122, 17'd79293, 17'd79483, 17'd79696, 17'd79934,
		17'd80200
	};

	// convert volts to ADC codes x16, rounded to nearest
	function automatic level_rom_t build_levels();
		level_rom_t      t;
		longint unsigned v;
		for (int i = 0; i < ROM_STORED; i++) begin
			v = (64'(VOLT_ROM[i]) * FS16 + ROM_HALF) / ROM_DEN;
			t[i] = v[LVL_W-1:0];
		end
		return t;
	endfunction

	localparam level_rom_t LEVEL_ROM = build_levels();

	// clamp past the table end to the last entry
	function automatic logic [LVL_W-1:0] rom_level(input logic [IDX_W-1:0] idx);
		logic [IDX_W:0] k;
		k = {1'b0, idx};
		if (k >= (IDX_W+1)'(TABLE_ENTRIES)) begin
			k = (IDX_W+1)'(TABLE_ENTRIES - 1);
		end
		if (k >= (IDX_W+1)'(ROM_STORED)) begin
			k = (IDX_W+1)'(ROM_STORED - 1);
		end
		return LEVEL_ROM[k[ROM_IDX_W-1:0]];
	endfunction

endpackage

@@ rtl/core/bsg_front.sv @@
module bsg_front import bsg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  soc_req_t req_data,
	output q_push_t  push,
	input  logic     push_ready
);

	logic     ent_valid_q;
	q_entry_t ent_q;
	logic     fire;

	assign fire      = ent_valid_q && push_ready;
	assign req_ready = !ent_valid_q || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			ent_valid_q <= 1'b1;
		end else if (fire) begin
			ent_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			ent_q.kind <= req_data.operation ? KIND_CLEAR : KIND_SAMPLE;
			ent_q.code <= req_data.adc_code;
		end
	end

	assign push.valid = ent_valid_q;
	assign push.entry = ent_q;

endmodule

@@ rtl/core/bsg_queue.sv @@
module bsg_queue import bsg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  q_push_t  push,
	output logic     push_ready,
	output logic     pop_valid,
	output q_entry_t pop_entry,
	input  logic     pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.entry;
		end
	end

endmodule

@@ rtl/core/bsg_back.sv @@
module bsg_back import bsg_pkg::*; #(
	parameter int AVG_LENGTH = AVG_LENGTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  soc_cfg_t cfg,
	input  logic     pop_valid,
	input  q_entry_t pop_entry,
	output logic     pop,
	output logic     res_valid,
	input  logic     res_ready,
	output soc_res_t res_data
);

	localparam int ADDR_W = (AVG_LENGTH > 1) ? $clog2(AVG_LENGTH) : 1;
	localparam int POS_W  = $clog2(AVG_LENGTH + 1);
	localparam int SUM_W  = ADC_BITS + $clog2(AVG_LENGTH);
	localparam int DVD_W  = SUM_W + 4;
	localparam int QSHIFT = DVD_W + $clog2(AVG_LENGTH);
	localparam int RCP_W  = DVD_W + 1;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((64'd1 << QSHIFT) + 64'(AVG_LENGTH) - 64'd1) / 64'(AVG_LENGTH));

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_UPDATE = 3'd2;
	localparam logic [2:0] ST_DIVIDE = 3'd3;
	localparam logic [2:0] ST_SEARCH = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [ADC_BITS-1:0] ring [AVG_LENGTH];

	logic [2:0]          state_q;
	logic [POS_W-1:0]    pos_q;
	logic [SUM_W-1:0]    sum_q;
	logic                full_q;
	logic                warn_q;
	logic [ADC_BITS-1:0] code_q;
	logic [ADC_BITS-1:0] rd_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [IDX_W-1:0]    id_q;
	soc_res_t            pend_q;
	soc_res_t            res_q;
	logic                res_valid_q;

	logic [ADDR_W-1:0]       addr;
	logic [SUM_W-1:0]        sum_new;
	logic [DVD_W+RCP_W-1:0]  prod;
	logic [AVG_W-1:0]        avg;
	logic [IDX_W:0]          id_next;
	logic [LVL_W:0]          mid_sum;
	logic [LVL_W:0]          avg_x2;
	logic                    step_up;
	logic                    ring_we;
	logic                    emit;

	assign addr     = pos_q[ADDR_W-1:0];
	assign sum_new  = sum_q - (full_q ? SUM_W'(rd_q) : '0) + SUM_W'(code_q);
	assign prod     = dvd_q * RECIP;
	assign avg      = dvd_q[AVG_W-1:0];
	assign id_next  = {1'b0, id_q} + 1'b1;
	assign mid_sum  = {1'b0, rom_level(id_q)} + {1'b0, rom_level(id_next[IDX_W-1:0])};
	assign avg_x2   = {avg, 1'b0};
	assign step_up  = (id_next < (IDX_W+1)'(TABLE_ENTRIES)) && (avg_x2 >= mid_sum);
	assign ring_we  = (state_q == ST_UPDATE);
	assign emit     = (state_q == ST_EMIT) && (!res_valid_q || res_ready);
	assign pop      = (state_q == ST_IDLE) && pop_valid;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[addr] <= code_q;
		end
		if (state_q == ST_READ) begin
			rd_q <= ring[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			sum_q       <= '0;
			full_q      <= 1'b0;
			warn_q      <= 1'b0;
			id_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						if (pop_entry.kind == KIND_CLEAR) begin
							pos_q   <= '0;
							sum_q   <= '0;
							full_q  <= 1'b0;
							state_q <= ST_EMIT;
						end else begin
							if (pos_q == POS_W'(AVG_LENGTH)) begin
								full_q <= 1'b1;
								pos_q  <= '0;
							end
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					sum_q  <= sum_new;
					pos_q  <= pos_q + 1'b1;
					state_q <= full_q ? ST_DIVIDE : ST_EMIT;
				end
				ST_DIVIDE: begin
					id_q    <= '0;
					state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (step_up) begin
						id_q <= id_next[IDX_W-1:0];
					end else begin
						if (id_q <= {1'b0, cfg.shutdown_max}) begin
							warn_q <= warn_q;
						end else if (id_q <= {1'b0, cfg.low_warn_max}) begin
							warn_q <= 1'b1;
						end else begin
							warn_q <= 1'b0;
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop_valid) begin
					code_q <= pop_entry.code;
					pend_q <= '0;
				end
			end
			ST_UPDATE: begin
				dvd_q <= {sum_new, 4'b0000};
				pend_q.average_level <= {code_q, 4'b0000};
			end
			ST_DIVIDE: begin
				dvd_q <= DVD_W'(prod[QSHIFT +: AVG_W]);
			end
			ST_SEARCH: begin
				if (!step_up) begin
					pend_q.soc_valid     <= 1'b1;
					pend_q.soc_percent   <= id_q[PCT_W-1:0];
					pend_q.average_level <= avg;
					pend_q.turn_on_ok    <= (avg > rom_level({1'b0, cfg.shutdown_max}));
					if (id_q <= {1'b0, cfg.shutdown_max}) begin
						pend_q.charge_band <= BAND_SHUTDOWN;
					end else if (id_q <= {1'b0, cfg.low_warn_max}) begin
						pend_q.charge_band <= BAND_LOW;
					end else begin
						pend_q.charge_band <= BAND_NORMAL;
					end
				end
			end
			default: begin
			end
		endcase
		if (emit) begin
			res_q <= {pend_q.soc_valid, pend_q.soc_percent, pend_q.charge_band, warn_q,
				pend_q.turn_on_ok, pend_q.average_level};
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

@@ rtl/core/battery_soc_gauge_top.sv @@
// Battery state-of-charge gauge.
// Requests enter on req_valid/req_ready with req_data (operation, adc_code); one result
// leaves per request on res_valid/res_ready with res_data. Operation 0 adds an ADC
// sample to a ring of AVG_LENGTH samples; operation 1 empties the window.
// Results come back in request order. Thresholds sit in two registers on the APB
// port: shutdown_max_percent at 0x0, low_warn_max_percent at 0x4.
// A sample on a full window adds a divide state (ST_DIVIDE) that divides the sum by
// AVG_LENGTH (reciprocal multiply) and a linear table search of one entry per cycle
// (up to 100 steps plus the final compare). The back end handles one request at a
// time; that sequencer sets the throughput.
// An input register and a two-entry queue keep accepting requests while the back
// end is busy or a result waits; when the receiver stalls, the finished result
// holds in the output register and the back end waits before its next result.
// Reset clears the window, the warning flag and the queue, and loads the
// thresholds with 5 and 20 percent.
module battery_soc_gauge_top import bsg_pkg::*; #(
	parameter int AVG_LENGTH = AVG_LENGTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  soc_req_t    req_data,
	output logic        res_valid,
	input  logic        res_ready,
	output soc_res_t    res_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	soc_cfg_t cfg_q;
	q_push_t  push;
	logic     push_ready;
	logic     pop_valid;
	q_entry_t pop_entry;
	logic     pop;
	logic     wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shutdown_max <= SHUTDOWN_RST;
			cfg_q.low_warn_max <= LOW_WARN_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_SHUTDOWN: cfg_q.shutdown_max <= pwdata[PCT_W-1:0];
				REG_LOW_WARN: cfg_q.low_warn_max <= pwdata[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_SHUTDOWN: prdata = {{(32-PCT_W){1'b0}}, cfg_q.shutdown_max};
			REG_LOW_WARN: prdata = {{(32-PCT_W){1'b0}}, cfg_q.low_warn_max};
			default:      prdata = '0;
		endcase
	end

	bsg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_data   (req_data),
		.push       (push),
		.push_ready (push_ready)
	);

	bsg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop        (pop)
	);

	bsg_back #(
		.AVG_LENGTH (AVG_LENGTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_entry (pop_entry),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

endmodule
